// ===== rtl/core/tree_entry_stream_parser_unit_defines.svh =====
// Assertion macros shared by the tree entry stream parser RTL.
`ifndef TREE_ENTRY_STREAM_PARSER_UNIT_DEFINES_SVH
`define TREE_ENTRY_STREAM_PARSER_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define TESP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TESP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tesp_pkg.sv =====
// Types, codes and defaults for the tree entry stream parser.
package tesp_pkg;

  localparam int MAX_ENTRIES_DEF     = 1024;
  localparam int HASH_BYTES_DEF      = 32;
  localparam int NAME_BYTES_DEF      = 256;
  localparam int MODE_TEXT_BYTES_DEF = 16;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;

  typedef enum logic [1:0] {
    PH_MODE,
    PH_NAME,
    PH_HASH
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_MODE,
    ROLE_SPACE,
    ROLE_NAME,
    ROLE_TERM,
    ROLE_HASH,
    ROLE_IGNORED
  } role_t;

  typedef enum logic [1:0] {
    ST_BUSY,
    ST_OK,
    ST_ERR
  } status_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] acc;
    logic        stopped;
    logic [7:0]  fc;
    logic        err;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:   PH_MODE,
    acc:     32'd0,
    stopped: 1'b0,
    fc:      8'd0,
    err:     1'b0
  };

  typedef struct packed {
    role_t       byte_role;
    logic [7:0]  byte_value;
    logic [9:0]  entry_index;
    logic [7:0]  field_offset;
    logic [31:0] mode_value;
    logic        entry_done;
    status_t     status;
    logic [10:0] entry_total;
  } result_t;

endpackage

// ===== rtl/core/tesp_if.sv =====
// Item channels of the tree entry stream parser: byte input and tagged result.
interface tesp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tesp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_role;
  logic [7:0]  byte_value;
  logic [9:0]  entry_index;
  logic [7:0]  field_offset;
  logic [31:0] mode_value;
  logic        entry_done;
  logic [1:0]  status;
  logic [10:0] entry_total;

  modport source (
    output valid, output byte_role, output byte_value, output entry_index,
    output field_offset, output mode_value, output entry_done, output status,
    output entry_total, input ready
  );
  modport sink (
    input valid, input byte_role, input byte_value, input entry_index,
    input field_offset, input mode_value, input entry_done, input status,
    input entry_total, output ready
  );
endinterface

// ===== rtl/core/tesp_step.sv =====
// Per-byte parse step: next parser state and the tagged result of one byte.
module tesp_step #(
  parameter int MAX_ENTRIES     = tesp_pkg::MAX_ENTRIES_DEF,
  parameter int HASH_BYTES      = tesp_pkg::HASH_BYTES_DEF,
  parameter int NAME_BYTES      = tesp_pkg::NAME_BYTES_DEF,
  parameter int MODE_TEXT_BYTES = tesp_pkg::MODE_TEXT_BYTES_DEF,
  localparam int CNT_W          = $clog2(MAX_ENTRIES + 1)
) (
  input  tesp_pkg::parse_state_t st,
  input  logic [CNT_W-1:0]       cnt,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output tesp_pkg::parse_state_t st_nxt,
  output logic [CNT_W-1:0]       cnt_nxt,
  output tesp_pkg::result_t      res
);

  localparam logic [CNT_W-1:0] MaxCnt  = CNT_W'(MAX_ENTRIES);
  localparam logic [8:0]       ModeLim = 9'(MODE_TEXT_BYTES);
  localparam logic [8:0]       NameLim = 9'(NAME_BYTES);
  localparam logic [8:0]       HashLim = 9'(HASH_BYTES);

  logic       limit;
  logic       at_limit;
  logic       clean;
  logic       is_digit;
  logic [8:0] fc_inc;

  assign limit    = (cnt >= MaxCnt);
  assign fc_inc   = {1'b0, st.fc} + 9'd1;
  assign is_digit = (data_byte >= tesp_pkg::CHAR_ZERO) && (data_byte <= tesp_pkg::CHAR_SEVEN);

  always_comb begin
    st_nxt   = st;
    cnt_nxt  = cnt;
    at_limit = 1'b0;
    clean    = 1'b0;
    res      = '{
      byte_role:    tesp_pkg::ROLE_IGNORED,
      byte_value:   data_byte,
      entry_index:  10'd0,
      field_offset: 8'd0,
      mode_value:   32'd0,
      entry_done:   1'b0,
      status:       tesp_pkg::ST_BUSY,
      entry_total:  11'd0
    };

    if (!st.err && !limit) begin
      res.entry_index = 10'(cnt);
      unique case (st.phase)
        tesp_pkg::PH_MODE: begin
          if (data_byte == tesp_pkg::CHAR_SPACE) begin
            res.byte_role    = tesp_pkg::ROLE_SPACE;
            res.field_offset = st.fc;
            res.mode_value   = st.acc;
            st_nxt.phase     = tesp_pkg::PH_NAME;
            st_nxt.fc        = 8'd0;
          end else if (fc_inc >= ModeLim) begin
            st_nxt.err      = 1'b1;
            res.entry_index = 10'd0;
          end else begin
            if (!st.stopped && is_digit) begin
              st_nxt.acc = {st.acc[28:0], 3'b000} + {29'd0, data_byte[2:0]};
            end else begin
              st_nxt.stopped = 1'b1;
            end
            res.byte_role    = tesp_pkg::ROLE_MODE;
            res.field_offset = st.fc;
            res.mode_value   = st_nxt.acc;
            st_nxt.fc        = fc_inc[7:0];
          end
        end
        tesp_pkg::PH_NAME: begin
          if (data_byte == tesp_pkg::CHAR_NUL) begin
            res.byte_role    = tesp_pkg::ROLE_TERM;
            res.field_offset = st.fc;
            res.mode_value   = st.acc;
            st_nxt.phase     = tesp_pkg::PH_HASH;
            st_nxt.fc        = 8'd0;
          end else if (fc_inc >= NameLim) begin
            st_nxt.err      = 1'b1;
            res.entry_index = 10'd0;
          end else begin
            res.byte_role    = tesp_pkg::ROLE_NAME;
            res.field_offset = st.fc;
            res.mode_value   = st.acc;
            st_nxt.fc        = fc_inc[7:0];
          end
        end
        tesp_pkg::PH_HASH: begin
          res.byte_role    = tesp_pkg::ROLE_HASH;
          res.field_offset = st.fc;
          res.mode_value   = st.acc;
          st_nxt.fc        = fc_inc[7:0];
          if (fc_inc >= HashLim) begin
            res.entry_done = 1'b1;
            cnt_nxt        = cnt + CNT_W'(1);
            st_nxt         = tesp_pkg::STATE_RESET;
          end
        end
        default: begin
          st_nxt = st;
        end
      endcase
    end

    res.entry_total = 11'(cnt_nxt);

    if (last_byte) begin
      at_limit = (cnt_nxt >= MaxCnt);
      clean    = (st_nxt.phase == tesp_pkg::PH_MODE) && (st_nxt.fc == 8'd0);
      priority if (st_nxt.err) begin
        res.status = tesp_pkg::ST_ERR;
      end else if (at_limit || clean) begin
        res.status = tesp_pkg::ST_OK;
      end else begin
        res.status = tesp_pkg::ST_ERR;
      end
      st_nxt  = tesp_pkg::STATE_RESET;
      cnt_nxt = '0;
    end
  end

endmodule

// ===== rtl/core/tesp_out_skid.sv =====
// Result register with a skid stage; input ready depends only on registered state.
`include "tree_entry_stream_parser_unit_defines.svh"

module tesp_out_skid (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  tesp_pkg::result_t     push_data,
  output logic                  can_push,
  tesp_out_if.source            out_ch
);

  logic              main_v_r, main_v_nxt;
  logic              skid_v_r, skid_v_nxt;
  tesp_pkg::result_t main_r, main_nxt;
  tesp_pkg::result_t skid_r, skid_nxt;
  logic              pop;

  assign can_push = !skid_v_r;
  assign pop      = main_v_r && out_ch.ready;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (pop || !main_v_r) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        main_v_nxt = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        main_nxt   = push_data;
        main_v_nxt = push;
      end
    end else if (push) begin
      skid_nxt   = push_data;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid        = main_v_r;
  assign out_ch.byte_role    = main_r.byte_role;
  assign out_ch.byte_value   = main_r.byte_value;
  assign out_ch.entry_index  = main_r.entry_index;
  assign out_ch.field_offset = main_r.field_offset;
  assign out_ch.mode_value   = main_r.mode_value;
  assign out_ch.entry_done   = main_r.entry_done;
  assign out_ch.status       = main_r.status;
  assign out_ch.entry_total  = main_r.entry_total;

  `TESP_ASSERT(a_skid_behind_main, clk, rst_n, (!skid_v_r || main_v_r), "skid full while result empty")
  `TESP_ASSERT_NEXT(a_skid_drains, clk, rst_n, (skid_v_r && out_ch.ready), (!skid_v_r), "skid not drained")

endmodule

// ===== rtl/core/tree_entry_stream_parser_unit.sv =====
// The result of an accepted byte is registered into the result stage and held there until taken.
// Throughput: one byte per cycle while the output takes results; a two-deep result stage keeps input ready
// while one result waits.
// Parser state is a single register set updated on each accepted byte.
// Reset (rst_n low, synchronous) returns the parser to the start of an object and
// empties the result stage.
`include "tree_entry_stream_parser_unit_defines.svh"

module tree_entry_stream_parser_unit #(
  parameter int MAX_ENTRIES     = tesp_pkg::MAX_ENTRIES_DEF,
  parameter int HASH_BYTES      = tesp_pkg::HASH_BYTES_DEF,
  parameter int NAME_BYTES      = tesp_pkg::NAME_BYTES_DEF,
  parameter int MODE_TEXT_BYTES = tesp_pkg::MODE_TEXT_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tesp_in_if.sink    in_ch,
  tesp_out_if.source out_ch
);

  localparam int               CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] MaxCnt  = CNT_W'(MAX_ENTRIES);
  localparam logic [7:0]       ModeLim = 8'(MODE_TEXT_BYTES);

  tesp_pkg::parse_state_t st_r, st_nxt;
  logic [CNT_W-1:0]       ent_cnt_r, ent_cnt_nxt;
  tesp_pkg::result_t      res;
  logic                   can_push;
  logic                   in_acc;

  assign in_ch.ready = can_push;
  assign in_acc      = in_ch.valid && can_push;

  tesp_step #(
    .MAX_ENTRIES     (MAX_ENTRIES),
    .HASH_BYTES      (HASH_BYTES),
    .NAME_BYTES      (NAME_BYTES),
    .MODE_TEXT_BYTES (MODE_TEXT_BYTES)
  ) u_step (
    .st        (st_r),
    .cnt       (ent_cnt_r),
    .data_byte (in_ch.data_byte),
    .last_byte (in_ch.last_byte),
    .st_nxt    (st_nxt),
    .cnt_nxt   (ent_cnt_nxt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= tesp_pkg::STATE_RESET;
      ent_cnt_r <= '0;
    end else if (in_acc) begin
      st_r      <= st_nxt;
      ent_cnt_r <= ent_cnt_nxt;
    end
  end

  tesp_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_data (res),
    .can_push  (can_push),
    .out_ch    (out_ch)
  );

  `TESP_ASSERT(a_cnt_bound, clk, rst_n, (ent_cnt_r <= MaxCnt), "entry count past limit")
  `TESP_ASSERT(a_mode_fc_bound, clk, rst_n, (st_r.phase != tesp_pkg::PH_MODE || st_r.fc < ModeLim), "mode text counter past limit")
  `TESP_ASSERT_NEXT(a_last_clears, clk, rst_n, (in_acc && in_ch.last_byte), (ent_cnt_r == '0 && !st_r.err && st_r.phase == tesp_pkg::PH_MODE && st_r.fc == 8'd0), "state not cleared after last item")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the tree entry stream parser: random and directed tree objects.
`timescale 1ns / 1ps

module tb_top;
  import tesp_pkg::*;

  localparam int MAX_ENT      = MAX_ENTRIES_DEF;
  localparam int HASH_LEN     = HASH_BYTES_DEF;
  localparam int NAME_TXT_MAX = NAME_BYTES_DEF;
  localparam int MODE_TXT_MAX = MODE_TEXT_BYTES_DEF;
  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT  = 2000000;

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;
  int   items_sent;
  int   cycles;

  always #1 clk = ~clk;

  tesp_in_if  in_ch ();
  tesp_out_if out_ch ();

  tree_entry_stream_parser_unit #(
    .MAX_ENTRIES     (MAX_ENT),
    .HASH_BYTES      (HASH_LEN),
    .NAME_BYTES      (NAME_TXT_MAX),
    .MODE_TEXT_BYTES (MODE_TXT_MAX)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  class byte_tag_scoreboard;
    phase_t      ph;
    logic [31:0] acc;
    bit          stopped;
    int          fc;
    int          entries;
    bit          err;
    result_t     expected_tags[$];
    int          mismatches;

    function new();
      clear_object();
      mismatches = 0;
    endfunction

    function void clear_object();
      ph      = PH_MODE;
      acc     = '0;
      stopped = 1'b0;
      fc      = 0;
      entries = 0;
      err     = 1'b0;
    endfunction

    // Tag an accepted byte and queue the result it should produce.
    function void tag_byte(logic [7:0] b, logic l);
      result_t r;
      r = '0;
      r.byte_role  = ROLE_IGNORED;
      r.byte_value = b;
      r.status     = ST_BUSY;
      if (!err && entries < MAX_ENT) begin
        r.entry_index = 10'(entries);
        case (ph)
          PH_MODE: begin
            if (b == CHAR_SPACE) begin
              r.byte_role    = ROLE_SPACE;
              r.field_offset = 8'(fc);
              r.mode_value   = acc;
              ph = PH_NAME;
              fc = 0;
            end else if (fc + 1 >= MODE_TXT_MAX) begin
              err = 1'b1;
              r.entry_index = '0;
            end else begin
              if (!stopped && b >= CHAR_ZERO && b <= CHAR_SEVEN)
                acc = (acc << 3) + 32'(b - CHAR_ZERO);
              else
                stopped = 1'b1;
              r.byte_role    = ROLE_MODE;
              r.field_offset = 8'(fc);
              r.mode_value   = acc;
              fc++;
            end
          end
          PH_NAME: begin
            if (b == CHAR_NUL) begin
              r.byte_role    = ROLE_TERM;
              r.field_offset = 8'(fc);
              r.mode_value   = acc;
              ph = PH_HASH;
              fc = 0;
            end else if (fc + 1 >= NAME_TXT_MAX) begin
              err = 1'b1;
              r.entry_index = '0;
            end else begin
              r.byte_role    = ROLE_NAME;
              r.field_offset = 8'(fc);
              r.mode_value   = acc;
              fc++;
            end
          end
          default: begin
            r.byte_role    = ROLE_HASH;
            r.field_offset = 8'(fc);
            r.mode_value   = acc;
            fc++;
            if (fc >= HASH_LEN) begin
              r.entry_done = 1'b1;
              entries++;
              ph      = PH_MODE;
              acc     = '0;
              stopped = 1'b0;
              fc      = 0;
            end
          end
        endcase
      end
      r.entry_total = 11'(entries);
      if (l) begin
        if (err)
          r.status = ST_ERR;
        else if (entries >= MAX_ENT || (ph == PH_MODE && fc == 0))
          r.status = ST_OK;
        else
          r.status = ST_ERR;
        clear_object();
      end
      expected_tags.push_back(r);
    endfunction

    function void compare_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch in %s: expected %0h, got %0h", what, want, got);
      end
    endfunction

    function void check_tag(result_t got);
      result_t want;
      if (expected_tags.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result item with no byte pending: value %0h", got.byte_value);
        return;
      end
      want = expected_tags.pop_front();
      compare_field("byte_role", want.byte_role, got.byte_role);
      compare_field("byte_value", want.byte_value, got.byte_value);
      compare_field("entry_index", want.entry_index, got.entry_index);
      compare_field("field_offset", want.field_offset, got.field_offset);
      compare_field("mode_value", want.mode_value, got.mode_value);
      compare_field("entry_done", want.entry_done, got.entry_done);
      compare_field("status", want.status, got.status);
      compare_field("entry_total", want.entry_total, got.entry_total);
    endfunction
  endclass

  byte_tag_scoreboard sb = new();

  // Mostly short idles, a few long ones.
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 1;
    if (r < 85) return $urandom_range(4, 2);
    if (r < 97) return $urandom_range(12, 5);
    return $urandom_range(40, 20);
  endfunction

  // Monitor: inputs noted before results checked, in one process.
  always @(posedge clk) begin
    result_t got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.tag_byte(in_ch.data_byte, in_ch.last_byte);
      if (out_ch.valid && out_ch.ready) begin
        got = '{byte_role:    role_t'(out_ch.byte_role),
                byte_value:   out_ch.byte_value,
                entry_index:  out_ch.entry_index,
                field_offset: out_ch.field_offset,
                mode_value:   out_ch.mode_value,
                entry_done:   out_ch.entry_done,
                status:       status_t'(out_ch.status),
                entry_total:  out_ch.entry_total};
        sb.check_tag(got);
      end
    end
  end

  // Result side back-pressure.
  initial begin
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(3) == 0)
          hold = idle_len();
      end
    end
  end

  task automatic push_byte(logic [7:0] b, logic l);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(9) < 4)
      gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= l;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_object(logic [7:0] q[$]);
    foreach (q[i])
      push_byte(q[i], i == q.size() - 1);
  endtask

  function automatic logic [7:0] mode_char();
    logic [7:0] b;
    if ($urandom_range(9) != 0)
      return CHAR_ZERO + 8'($urandom_range(7));
    b = 8'($urandom_range(255));
    if (b == CHAR_SPACE)
      b = 8'h21;
    return b;
  endfunction

  function automatic void add_entry(ref logic [7:0] q[$], input int mlen, input int nlen);
    repeat (mlen) q.push_back(mode_char());
    q.push_back(CHAR_SPACE);
    repeat (nlen) q.push_back(8'($urandom_range(255, 1)));
    q.push_back(CHAR_NUL);
    repeat (HASH_LEN) q.push_back(8'($urandom_range(255)));
  endfunction

  function automatic int pick_mode_size();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 70) return $urandom_range(6, 5);
    return $urandom_range(MODE_TXT_MAX - 1, 1);
  endfunction

  function automatic int pick_name_size();
    int r;
    r = $urandom_range(99);
    if (r < 3) return NAME_TXT_MAX - 1;
    if (r < 6) return 0;
    return $urandom_range(24, 1);
  endfunction

  task automatic directed_objects();
    logic [7:0] q[$];
    send_object({8'hFF});
    send_object({CHAR_SPACE});
    // widest mode value, name byte extremes, hash byte extremes
    q = {};
    repeat (13) q.push_back(CHAR_SEVEN);
    q = {q, CHAR_SPACE, 8'h01, 8'hFF, CHAR_NUL, 8'h00, 8'hFF, CHAR_SPACE};
    repeat (HASH_LEN - 3) q.push_back(8'($urandom_range(255)));
    send_object(q);
    // digits stop at the first non-octal byte; object cut at terminator
    send_object({8'h31, 8'h38, 8'h37, CHAR_SPACE, 8'h78, CHAR_NUL});
    // mode text too long, offending byte is the last
    q = {};
    repeat (MODE_TXT_MAX) q.push_back(CHAR_ZERO);
    send_object(q);
  endtask

  task automatic random_object();
    logic [7:0] q[$];
    int kind;
    int n;
    kind = $urandom_range(99);
    n = $urandom_range(4, 1);
    calm = ($urandom_range(4) == 0);
    if (kind < 8) begin
      repeat ($urandom_range(40, 1)) q.push_back(8'($urandom_range(255)));
    end else begin
      repeat (n) add_entry(q, pick_mode_size(), pick_name_size());
      if (kind < 20) begin
        q = q[0:$urandom_range(q.size() - 1)];
      end else if (kind < 28) begin
        if ($urandom_range(3) == 0)
          add_entry(q, pick_mode_size(), $urandom_range(NAME_TXT_MAX + 2, NAME_TXT_MAX));
        else
          add_entry(q, $urandom_range(MODE_TXT_MAX + 2, MODE_TXT_MAX), 3);
        if ($urandom_range(1) == 0)
          add_entry(q, pick_mode_size(), pick_name_size());
      end
    end
    send_object(q);
  endtask

  initial begin
    rst_n           <= 1'b0;
    calm            = 1'b0;
    items_sent      = 0;
    cycles          = 0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_objects();
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS)
      random_object();

    in_ch.valid <= 1'b0;
    calm = 1'b0;
    while (sb.expected_tags.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (sb.mismatches == 0 && sb.expected_tags.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
